// ===== sv/acw_pkg.sv =====
// Shared types, codes and constants for the AIMD congestion window block.
package acw_pkg;

  // Default number of fraction bits in the window and threshold words.
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Register reset values.
  localparam logic [15:0] RTT_TIMEOUT_RST  = 16'd105;
  localparam logic [31:0] START_WINDOW_RST = 32'd65536;
  localparam logic [31:0] START_THRESH_RST = 32'd4194304;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RTT_TIMEOUT  = 2'd0,
    CFG_START_WINDOW = 2'd1,
    CFG_START_THRESH = 2'd2
  } cfg_idx_e;

  // Window update selected by the controller.
  typedef enum logic [1:0] {
    OP_INC = 2'd0,
    OP_DIV = 2'd1,
    OP_CUT = 2'd2
  } op_e;

  // Input request payload.
  typedef struct packed {
    logic [31:0] send_time_ms;
    logic [31:0] ack_time_ms;
  } ack_req_t;

  // Result payload.
  typedef struct packed {
    logic [31:0] window_fixed;
    logic [15:0] window_datagrams;
    logic [31:0] threshold_fixed;
    logic        congestion_seen;
  } result_t;

  // Configuration write payload.
  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic commit;
    op_e  op;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic congested;
    logic at_or_below;
    logic div_last;
  } dp_status_t;

endpackage

// ===== sv/acw_stream_if.sv =====
// Valid/ready channel carrying one request payload of a given type.
interface acw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/acw_datapath.sv =====
// Datapath: registers, window state, radix-2 divider and update logic.
module acw_datapath
  import acw_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ack_req_t   ack_data_i,
  input  logic       cfg_we_i,
  input  cfg_req_t   cfg_data_i,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t status_o,
  output result_t    res_data_o
);

  // Quotient of 2 << (2*FRACTION_BITS) needs 2*FRACTION_BITS+2 bits.
  localparam int unsigned QW    = 2 * FRACTION_BITS + 2;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam int unsigned SUM_W = ((QW > 32) ? QW : 32) + 1;
  localparam logic [31:0] ONE   = 32'd1 << FRACTION_BITS;
  localparam logic [31:0] THREE = 32'd3 << FRACTION_BITS;

  logic [15:0]      timeout_q;
  logic [31:0]      window_q, window_d;
  logic [31:0]      thresh_q, thresh_d;
  logic [31:0]      rtt_q;
  logic [31:0]      rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  result_t          res_q;

  // Comparisons that steer the controller.
  assign status_o.congested   = (rtt_q > {16'd0, timeout_q});
  assign status_o.at_or_below = (window_q <= thresh_q);
  assign status_o.div_last    = (cnt_q == CNT_W'(QW - 1));

  // One restoring division step; the dividend has a single one at its top bit.
  logic        bit_in;
  logic [32:0] trial, diff;
  logic        fits;
  always_comb begin
    bit_in = (cnt_q == '0);
    trial  = {rem_q, bit_in};
    fits   = (trial >= {1'b0, window_q});
    diff   = trial - {1'b0, window_q};
    rem_d  = fits ? diff[31:0] : trial[31:0];
    quo_d  = {quo_q[QW-2:0], fits};
  end

  // New window and threshold for the selected update.
  logic [SUM_W-1:0] sum;
  logic [31:0]      grown, whole_full;
  logic [15:0]      whole;
  always_comb begin
    sum   = SUM_W'(window_q) + ((cmd_i.op == OP_INC) ? SUM_W'(ONE) : SUM_W'(quo_q));
    grown = (|sum[SUM_W-1:32]) ? 32'hFFFF_FFFF : sum[31:0];
    thresh_d = thresh_q;
    case (cmd_i.op)
      OP_INC, OP_DIV: window_d = grown;
      OP_CUT: begin
        window_d = THREE;
        thresh_d = (window_q >> 1) + ONE;
      end
      default: window_d = window_q;
    endcase
    if (window_d < ONE) begin
      window_d = ONE;
    end
    whole_full = window_d >> FRACTION_BITS;
    whole      = (|whole_full[31:16]) ? 16'hFFFF : whole_full[15:0];
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= RTT_TIMEOUT_RST;
      window_q  <= START_WINDOW_RST;
      thresh_q  <= START_THRESH_RST;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_data_i.index))
          CFG_RTT_TIMEOUT:  timeout_q <= cfg_data_i.value[15:0];
          CFG_START_WINDOW: window_q  <= cfg_data_i.value;
          CFG_START_THRESH: thresh_q  <= cfg_data_i.value;
          default: ;
        endcase
      end else if (cmd_i.commit) begin
        window_q <= window_d;
        thresh_q <= thresh_d;
      end
      if (cmd_i.div_start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Payload registers: RTT, divider and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rtt_q <= ack_data_i.ack_time_ms - ack_data_i.send_time_ms;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.commit) begin
      res_q.window_fixed     <= window_d;
      res_q.window_datagrams <= whole;
      res_q.threshold_fixed  <= thresh_d;
      res_q.congestion_seen  <= (cmd_i.op == OP_CUT);
    end
  end

  assign res_data_o = res_q;

`ifndef SYNTHESIS
  // A committed window is never below one datagram.
  a_window_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !cfg_we_i |=> window_q >= ONE)
    else $error("window below one after update");

  // A cut leaves the window at three datagrams.
  a_cut_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !cfg_we_i && cmd_i.op == OP_CUT |=> window_q == THREE)
    else $error("cut did not set window to three");

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> rem_q < window_q)
    else $error("divider remainder out of range");
`endif

endmodule

// ===== sv/acw_controller.sv =====
// Controller: sequences accept, evaluate, divide and commit for each request.
module acw_controller
  import acw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ack_valid_i,
  output logic       ack_ready_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_COMMIT
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic   res_valid_q;
  logic   slot_free;

  // The result register may be refilled when empty or drained this cycle.
  assign slot_free   = !res_valid_q || res_ready_i;
  assign ack_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;

  assign cmd_o.load      = (state_q == ST_IDLE) && ack_valid_i;
  assign cmd_o.div_start = (state_q == ST_EVAL);
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.commit    = (state_q == ST_COMMIT) && slot_free;
  assign cmd_o.op        = op_q;

  // State, selected update and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_INC;
      res_valid_q <= 1'b0;
    end else begin
      // A drained result clears the flag unless a new one replaces it now.
      if (res_valid_q && res_ready_i && !cmd_o.commit) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (ack_valid_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (status_i.congested) begin
            op_q    <= OP_CUT;
            state_q <= ST_COMMIT;
          end else if (status_i.at_or_below) begin
            op_q    <= OP_INC;
            state_q <= ST_COMMIT;
          end else begin
            op_q    <= OP_DIV;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (status_i.div_last) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A commit always produces a pending result next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> res_valid_q)
    else $error("commit without result");

  // A result that waits is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i |-> !cmd_o.commit)
    else $error("pending result overwritten");

  // The last divider step leads straight to the commit.
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step && status_i.div_last |=> state_q == ST_COMMIT)
    else $error("divider end not followed by commit");
`endif

endmodule

// ===== sv/aimd_congestion_window.sv =====
// Top level of the AIMD congestion window block.
// Each accepted acknowledgement request updates the congestion window and
// produces one result request. An acknowledgement is taken in the idle
// state and evaluated in the cycle after it. A growth step at or below the
// threshold and a congestion cut then go to the commit state, which waits
// until the output register is free. Above the threshold the 2/window step
// runs through a radix-2 restoring divider, one quotient bit per cycle, for
// 2*FRACTION_BITS+2 quotient bits (34 at the default of 16). One request is
// in work at a time; a finished result sits in an output register, so the
// next acknowledgement is taken while the previous result still waits.
// Configuration writes are always ready and take effect at once; writing
// the start window or start threshold also loads the live value.
module aimd_congestion_window
  import acw_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  acw_stream_if.sink   ack_i,
  acw_stream_if.source res_o,
  acw_stream_if.sink   cfg_i
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       cfg_we;
  ack_req_t   ack_data;
  cfg_req_t   cfg_data;
  result_t    res_data;

  // Configuration writes are taken in every cycle.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cfg_data    = cfg_i.data;
  assign ack_data    = ack_i.data;
  assign res_o.data  = res_data;

  acw_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ack_valid_i (ack_i.valid),
    .ack_ready_o (ack_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  acw_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ack_data_i (ack_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_data_o (res_data)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the AIMD congestion window block.
module testbench;
  import acw_pkg::*;

  localparam int unsigned FRAC_BITS = FRACTION_BITS_DEF;
  localparam logic [63:0] ONE_FIXED = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MAX_WORD = 64'hFFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned RUN_LIMIT = 8 * 3_000_000;
  localparam int unsigned TAIL_CYCLES = 60;

  logic clk_i;
  logic rst_ni;

  acw_stream_if #(.T(ack_req_t)) ack_if ();
  acw_stream_if #(.T(result_t))  res_if ();
  acw_stream_if #(.T(cfg_req_t)) cfg_if ();

  aimd_congestion_window #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ack_i (ack_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the registers and the window state.
  logic [15:0] rtt_limit   = RTT_TIMEOUT_RST;
  logic [31:0] cwnd        = START_WINDOW_RST;
  logic [31:0] ssthresh    = START_THRESH_RST;

  result_t window_updates[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_active = 1'b0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #(RUN_LIMIT);
    $display("aimd_congestion_window test failed");
    $finish;
  end

  // Result ready, with random stalls and an optional long hold-off.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Computes the window update caused by one acknowledgement.
  function automatic result_t next_window(input ack_req_t req);
    logic [31:0] rtt;
    logic [63:0] grown;
    logic [63:0] whole;
    result_t r;
    rtt = req.ack_time_ms - req.send_time_ms;
    r.congestion_seen = 1'b0;
    if (rtt <= {16'd0, rtt_limit}) begin
      // Slow start at or below the threshold, additive increase above it.
      if (cwnd <= ssthresh) begin
        grown = {32'd0, cwnd} + ONE_FIXED;
      end else begin
        grown = {32'd0, cwnd} + ((64'd2 << (2 * FRAC_BITS)) / {32'd0, cwnd});
      end
      cwnd = (grown > MAX_WORD) ? MAX_WORD[31:0] : grown[31:0];
    end else begin
      // Multiplicative decrease on a late acknowledgement.
      grown = {33'd0, cwnd[31:1]} + ONE_FIXED;
      ssthresh = grown[31:0];
      grown = 3 * ONE_FIXED;
      cwnd = grown[31:0];
      r.congestion_seen = 1'b1;
    end
    if ({32'd0, cwnd} < ONE_FIXED) cwnd = ONE_FIXED[31:0];
    whole = {32'd0, cwnd} >> FRAC_BITS;
    r.window_datagrams = (whole > 64'hFFFF) ? 16'hFFFF : whole[15:0];
    r.window_fixed = cwnd;
    r.threshold_fixed = ssthresh;
    return r;
  endfunction

  // Random acknowledgement: mostly on time, some late, some arbitrary.
  function automatic ack_req_t random_ack();
    ack_req_t req;
    logic [31:0] rtt;
    int unsigned pick;
    pick = $urandom_range(99);
    req.send_time_ms = $urandom;
    if (pick < 80) begin
      rtt = $urandom_range(rtt_limit, 0);
    end else if (pick < 92) begin
      rtt = {16'd0, rtt_limit} + 32'd1 + $urandom_range(1000);
    end else begin
      rtt = $urandom;
    end
    req.ack_time_ms = req.send_time_ms + rtt;
    return req;
  endfunction

  function automatic ack_req_t ack_with(input logic [31:0] send_ms, input logic [31:0] ack_ms);
    ack_req_t req;
    req.send_time_ms = send_ms;
    req.ack_time_ms = ack_ms;
    return req;
  endfunction

  // Sends one acknowledgement request. Valid is left high on return.
  task automatic send_ack(input ack_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      ack_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    ack_if.valid <= 1'b1;
    ack_if.data <= req;
    do @(posedge clk_i); while (!ack_if.ready);
    window_updates.push_back(next_window(req));
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_drain();
    ack_if.valid <= 1'b0;
    do @(negedge clk_i); while (window_updates.size() != 0);
  endtask

  // Writes one configuration register; the block must be idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_req_t req;
    req.index = idx;
    req.value = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= req;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (cfg_idx_e'(idx))
      CFG_RTT_TIMEOUT: rtt_limit = value[15:0];
      CFG_START_WINDOW: cwnd = value;
      CFG_START_THRESH: ssthresh = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (window_updates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = window_updates.pop_front();
        report_field("window_fixed", want.window_fixed, got.window_fixed);
        report_field("window_datagrams", {16'd0, want.window_datagrams},
                     {16'd0, got.window_datagrams});
        report_field("threshold_fixed", want.threshold_fixed, got.threshold_fixed);
        report_field("congestion_seen", {31'd0, want.congestion_seen},
                     {31'd0, got.congestion_seen});
      end
    end
  end

  // Reset values: on-time edges, the timeout boundary and clock wrap.
  task automatic test_reset_defaults();
    send_ack(ack_with(32'd0, 32'd0));
    send_ack(ack_with(32'hFFFF_FFFF, 32'd104));
    send_ack(ack_with(32'd5000, 32'd5106));
    send_ack(ack_with(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_ack(ack_with(32'd1000, 32'd999));
    wait_drain();
  endtask

  // Register extremes: both branches, division, saturation, a zero start
  // window and a write to an unused register index.
  task automatic test_register_extremes();
    write_reg(CFG_RTT_TIMEOUT, 32'h0000_FFFF);
    write_reg(CFG_START_THRESH, 32'd0);
    write_reg(CFG_START_WINDOW, 32'd65536);
    for (int i = 0; i < 4; i++) send_ack(ack_with(32'h8000_0000, 32'h8000_FFFF));
    send_ack(ack_with(32'h8000_0000, 32'h8001_0000));
    wait_drain();

    write_reg(CFG_RTT_TIMEOUT, 32'd0);
    write_reg(CFG_START_THRESH, 32'hFFFF_FFFF);
    write_reg(CFG_START_WINDOW, 32'd0);
    send_ack(ack_with(32'h1234_5678, 32'h1234_5678));
    wait_drain();
    write_reg(CFG_START_WINDOW, 32'd1);
    send_ack(ack_with(32'h0F0F_0F0F, 32'h0F0F_0F0F));
    send_ack(ack_with(32'd7, 32'd8));
    wait_drain();

    // Overflow on both growth branches, then a cut from the top.
    write_reg(CFG_RTT_TIMEOUT, 32'd105);
    write_reg(CFG_START_WINDOW, 32'hFFFF_0000);
    send_ack(ack_with(32'd10, 32'd15));
    send_ack(ack_with(32'd10, 32'd15));
    wait_drain();
    write_reg(CFG_START_THRESH, 32'd0);
    send_ack(ack_with(32'd10, 32'd115));
    send_ack(ack_with(32'd10, 32'd200));
    wait_drain();

    // Unused index must leave every register alone.
    write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    send_ack(ack_with(32'd0, 32'd1));
    wait_drain();
  endtask

  // A random but legal register setting, often at an extreme.
  task automatic random_settings();
    case ($urandom_range(3))
      0: write_reg(CFG_RTT_TIMEOUT, 32'd0);
      1: write_reg(CFG_RTT_TIMEOUT, 32'h0000_FFFF);
      default: write_reg(CFG_RTT_TIMEOUT, $urandom_range(500, 20));
    endcase
    case ($urandom_range(7))
      0: write_reg(CFG_START_THRESH, 32'd0);
      1: write_reg(CFG_START_THRESH, 32'hFFFF_FFFF);
      default: write_reg(CFG_START_THRESH, $urandom_range(32 << 16, 0));
    endcase
    case ($urandom_range(7))
      0: write_reg(CFG_START_WINDOW, 32'd0);
      1: write_reg(CFG_START_WINDOW, 32'hFFFF_FFFF);
      default: write_reg(CFG_START_WINDOW, $urandom_range(64 << 16, 1 << 16));
    endcase
  endtask

  // One random phase with the given sender idling and receiver stalling.
  task automatic test_random_phase(input int unsigned count, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    wait_drain();
    random_settings();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_ack(random_ack());
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_holdoff();
    wait_drain();
    random_settings();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_active = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_active = 1'b0;
      end
    join_none
    repeat (24) send_ack(random_ack());
    wait_drain();
  endtask

  // The sender pauses between bursts until every result is back.
  task automatic test_drain_pauses();
    send_idle_pct = 38;
    recv_stall_pct = 38;
    repeat (3) begin
      repeat (6) send_ack(random_ack());
      wait_drain();
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    ack_if.valid = 1'b0;
    ack_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_output_holdoff();
    test_drain_pauses();
    repeat (2) begin
      test_random_phase(192, 0, 0);
      test_random_phase(192, 67, 0);
      test_random_phase(192, 0, 67);
      test_random_phase(192, 38, 38);
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && window_updates.size() == 0) begin
      $display("aimd_congestion_window test passed");
    end else begin
      $display("aimd_congestion_window test failed");
    end
    $finish;
  end

endmodule
